// ----- rtl/frame_difference_motion_detect_assert.svh -----
// Assertion macros shared by the motion detector modules.
// Expects clk and rst_n in the scope of each use.
`ifndef FRAME_DIFFERENCE_MOTION_DETECT_ASSERT_SVH
`define FRAME_DIFFERENCE_MOTION_DETECT_ASSERT_SVH

// same-cycle implication
`define FDMD_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define FDMD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/fdmd_pkg.sv -----
// Shared constants and types for the frame difference motion detector.
// No dependencies.
package fdmd_pkg;

  localparam int MAX_PIXELS_DEF = 524288;

  localparam int LUMA_W     = 8;
  localparam int FRAME_W    = 20;
  localparam int THRESH_W   = 10;
  localparam int VERDICT_W  = 2;
  localparam int DIFF_W     = 27;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [FRAME_W-1:0]  FRAME_PIXELS_RST = 20'd307200;
  localparam logic [THRESH_W-1:0] THRESH_RST       = 10'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 1'd1;

  localparam logic [VERDICT_W-1:0] VERDICT_FIRST  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_MOTION = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_STILL  = 2'd2;

  localparam int PERMILLE_SCALE = 1000;
  localparam int SCALE_W        = 10;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 4);

  typedef struct packed {
    logic valid;
    logic first;
  } frame_ev_t;

endpackage

// ----- rtl/frame_difference_motion_detect.sv -----
// Frame difference motion detector: one luma word per cycle while in_stall is low,
// one result per frame, registered through stage 1, the event and stage 3 registers.
// Throughput: 1 pixel word per unstalled cycle, one read-first store access per pixel.
// Reset (synchronous): position, accumulator and result queue clear; frame size 307200,
// threshold 4 permille. The frame store is not cleared; the first frame fills it.
// Depends on fdmd_pkg, fdmd_store, fdmd_accum and fdmd_verdict.
module frame_difference_motion_detect #(
  parameter int MAX_PIXELS = fdmd_pkg::MAX_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fdmd_pkg::LUMA_W-1:0]     in_luma,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fdmd_pkg::VERDICT_W-1:0]  out_verdict,
  output logic [fdmd_pkg::DIFF_W-1:0]     out_diff_sum,
  input  logic                            cfg_we,
  input  logic [fdmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_PIXELS);
  localparam int NW = AW + 1;
  localparam int SW = AW + fdmd_pkg::LUMA_W;
  localparam int CW = (NW > fdmd_pkg::FRAME_W) ? NW : fdmd_pkg::FRAME_W;
  localparam logic [CW-1:0] MAX_EXT = CW'(MAX_PIXELS);

  logic [fdmd_pkg::FRAME_W-1:0]  frame_pixels_r;
  logic [fdmd_pkg::THRESH_W-1:0] thresh_r;

  logic [CW-1:0]                 fp_ext;
  logic [NW-1:0]                 n_eff;
  logic                          accept;
  logic [AW-1:0]                 addr;
  logic [fdmd_pkg::LUMA_W-1:0]   rdata;
  logic                          s1_pend;
  fdmd_pkg::frame_ev_t           ev;
  logic [SW-1:0]                 sum;
  logic [fdmd_pkg::OCC_W-1:0]    occ;
  logic [fdmd_pkg::OCC_W-1:0]    load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pixels_r <= fdmd_pkg::FRAME_PIXELS_RST;
      thresh_r       <= fdmd_pkg::THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fdmd_pkg::CFG_FRAME_PIXELS: frame_pixels_r <= cfg_wdata[fdmd_pkg::FRAME_W-1:0];
        fdmd_pkg::CFG_THRESHOLD:    thresh_r       <= cfg_wdata[fdmd_pkg::THRESH_W-1:0];
      endcase
    end
  end

  // clamp frame size to 1..MAX_PIXELS
  assign fp_ext = CW'(frame_pixels_r);
  always_comb begin
    if (fp_ext == '0) begin
      n_eff = NW'(1);
    end else if (fp_ext > MAX_EXT) begin
      n_eff = NW'(MAX_PIXELS);
    end else begin
      n_eff = NW'(fp_ext);
    end
  end

  // hold input while results in flight could overrun the queue
  assign load     = occ + fdmd_pkg::OCC_W'(s1_pend);
  assign in_stall = load >= fdmd_pkg::OCC_W'(fdmd_pkg::FIFO_DEPTH);
  assign accept   = in_valid && !in_stall;

  fdmd_store #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .en    (accept),
    .addr  (addr),
    .wdata (in_luma),
    .rdata (rdata)
  );

  fdmd_accum #(
    .AW (AW),
    .NW (NW),
    .SW (SW)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .luma    (in_luma),
    .n_eff   (n_eff),
    .rdata   (rdata),
    .addr    (addr),
    .s1_pend (s1_pend),
    .ev      (ev),
    .sum     (sum)
  );

  fdmd_verdict #(
    .NW (NW),
    .SW (SW)
  ) u_verdict (
    .clk          (clk),
    .rst_n        (rst_n),
    .ev           (ev),
    .sum          (sum),
    .n_eff        (n_eff),
    .thresh       (thresh_r),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_verdict  (out_verdict),
    .out_diff_sum (out_diff_sum),
    .occ          (occ)
  );

endmodule

// ----- rtl/fdmd_store.sv -----
// Previous-frame store: one luma word per pixel position, read-first.
// Depends on fdmd_pkg.
module fdmd_store #(
  parameter int DEPTH = fdmd_pkg::MAX_PIXELS_DEF,
  parameter int AW    = $clog2(fdmd_pkg::MAX_PIXELS_DEF)
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [AW-1:0]               addr,
  input  logic [fdmd_pkg::LUMA_W-1:0] wdata,
  output logic [fdmd_pkg::LUMA_W-1:0] rdata
);

  logic [fdmd_pkg::LUMA_W-1:0] mem_r [DEPTH];
  logic [fdmd_pkg::LUMA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r     <= mem_r[addr];
      mem_r[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/fdmd_accum.sv -----
// Pixel position counter and absolute difference accumulator.
// Depends on fdmd_pkg and the assertion macro header.
`include "frame_difference_motion_detect_assert.svh"
module fdmd_accum #(
  parameter int AW = $clog2(fdmd_pkg::MAX_PIXELS_DEF),
  parameter int NW = AW + 1,
  parameter int SW = AW + fdmd_pkg::LUMA_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [fdmd_pkg::LUMA_W-1:0] luma,
  input  logic [NW-1:0]               n_eff,
  input  logic [fdmd_pkg::LUMA_W-1:0] rdata,
  output logic [AW-1:0]               addr,
  output logic                        s1_pend,
  output fdmd_pkg::frame_ev_t         ev,
  output logic [SW-1:0]               sum
);

  logic [AW-1:0]               idx_r;
  logic                        have_ref_r;
  logic                        s1_vld_r;
  logic                        s1_last_r;
  logic                        s1_first_r;
  logic [fdmd_pkg::LUMA_W-1:0] s1_luma_r;
  logic [SW-1:0]               acc_r;
  fdmd_pkg::frame_ev_t         ev_r;
  logic [SW-1:0]               sum_r;

  logic [NW-1:0]               idx_inc;
  logic                        last;
  logic [fdmd_pkg::LUMA_W-1:0] diff;
  logic [fdmd_pkg::LUMA_W-1:0] add;
  logic [SW-1:0]               acc_sum;

  assign idx_inc = {1'b0, idx_r} + NW'(1);
  assign last    = idx_inc >= n_eff;

  assign diff    = (s1_luma_r > rdata) ? (s1_luma_r - rdata) : (rdata - s1_luma_r);
  assign add     = s1_first_r ? '0 : diff;
  assign acc_sum = acc_r + SW'(add);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      have_ref_r <= 1'b0;
      s1_vld_r   <= 1'b0;
      s1_last_r  <= 1'b0;
      s1_first_r <= 1'b0;
      acc_r      <= '0;
      ev_r       <= '0;
    end else begin
      s1_vld_r <= accept;
      if (accept) begin
        s1_last_r  <= last;
        s1_first_r <= !have_ref_r;
        idx_r      <= last ? '0 : idx_r + AW'(1);
        if (last) begin
          have_ref_r <= 1'b1;
        end
      end
      if (s1_vld_r) begin
        acc_r <= s1_last_r ? '0 : acc_sum;
      end
      ev_r.valid <= s1_vld_r && s1_last_r;
      ev_r.first <= s1_first_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_luma_r <= luma;
    end
    sum_r <= acc_sum;
  end

  assign addr    = idx_r;
  assign s1_pend = s1_vld_r && s1_last_r;
  assign ev      = ev_r;
  assign sum     = sum_r;

  `FDMD_ASSERT_NEXT(a_idx_wrap, accept && last, idx_r == '0, "position did not wrap at frame end")
  `FDMD_ASSERT_NEXT(a_ref_hold, have_ref_r, have_ref_r, "reference flag dropped")
  `FDMD_ASSERT_NOW(a_first_zero, ev_r.valid && ev_r.first, sum_r == '0, "first frame sum not zero")

endmodule

// ----- rtl/fdmd_verdict.sv -----
// Threshold compare and result queue for the motion detector.
// Depends on fdmd_pkg and the assertion macro header.
`include "frame_difference_motion_detect_assert.svh"
module fdmd_verdict #(
  parameter int NW = $clog2(fdmd_pkg::MAX_PIXELS_DEF) + 1,
  parameter int SW = $clog2(fdmd_pkg::MAX_PIXELS_DEF) + fdmd_pkg::LUMA_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fdmd_pkg::frame_ev_t            ev,
  input  logic [SW-1:0]                  sum,
  input  logic [NW-1:0]                  n_eff,
  input  logic [fdmd_pkg::THRESH_W-1:0]  thresh,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [fdmd_pkg::VERDICT_W-1:0] out_verdict,
  output logic [fdmd_pkg::DIFF_W-1:0]    out_diff_sum,
  output logic [fdmd_pkg::OCC_W-1:0]     occ
);

  localparam int LW  = SW + fdmd_pkg::SCALE_W;
  localparam int N8W = NW + fdmd_pkg::LUMA_W;
  localparam int RW  = N8W + fdmd_pkg::THRESH_W;
  localparam int MW  = (LW > RW) ? LW : RW;
  localparam int CNT_W = fdmd_pkg::FIFO_AW + 1;

  logic [N8W-1:0]                  n255_r;
  logic [RW-1:0]                   rhs_r;
  logic                            s3_vld_r;
  logic                            s3_first_r;
  logic [LW-1:0]                   s3_lhs_r;
  logic [fdmd_pkg::DIFF_W-1:0]     s3_sum_r;

  logic [fdmd_pkg::VERDICT_W-1:0]  fifo_verdict_r [fdmd_pkg::FIFO_DEPTH];
  logic [fdmd_pkg::DIFF_W-1:0]     fifo_diff_r    [fdmd_pkg::FIFO_DEPTH];
  logic [fdmd_pkg::FIFO_AW-1:0]    wr_ptr_r;
  logic [fdmd_pkg::FIFO_AW-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]                cnt_r;

  logic                            motion;
  logic [fdmd_pkg::VERDICT_W-1:0]  verdict_nxt;
  logic                            push;
  logic                            pop;

  assign motion      = MW'(s3_lhs_r) > MW'(rhs_r);
  assign verdict_nxt = s3_first_r ? fdmd_pkg::VERDICT_FIRST :
                       motion     ? fdmd_pkg::VERDICT_MOTION : fdmd_pkg::VERDICT_STILL;
  assign push        = s3_vld_r;
  assign pop         = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    n255_r     <= {n_eff, {fdmd_pkg::LUMA_W{1'b0}}} - N8W'(n_eff);
    rhs_r      <= RW'(n255_r) * RW'(thresh);
    s3_first_r <= ev.first;
    s3_lhs_r   <= LW'(sum) * LW'(fdmd_pkg::PERMILLE_SCALE);
    s3_sum_r   <= fdmd_pkg::DIFF_W'(sum);
    if (push) begin
      fifo_verdict_r[wr_ptr_r] <= verdict_nxt;
      fifo_diff_r[wr_ptr_r]    <= s3_sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      s3_vld_r <= ev.valid;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + fdmd_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + fdmd_pkg::FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign out_valid    = cnt_r != '0;
  assign out_verdict  = fifo_verdict_r[rd_ptr_r];
  assign out_diff_sum = fifo_diff_r[rd_ptr_r];
  assign occ          = fdmd_pkg::OCC_W'(cnt_r) + fdmd_pkg::OCC_W'(s3_vld_r)
                      + fdmd_pkg::OCC_W'(ev.valid);

  `FDMD_ASSERT_NOW(a_no_overflow, push && !pop, cnt_r < CNT_W'(fdmd_pkg::FIFO_DEPTH), "result queue overflow")
  `FDMD_ASSERT_NOW(a_first_out, out_valid && out_verdict == fdmd_pkg::VERDICT_FIRST, out_diff_sum == '0, "first frame result carries a sum")

endmodule
